// File: rtl/tun_pkg.sv
// Shared widths, status codes and payload types for the triangle unit normal block.
// No dependencies; used by tun_isqrt, tun_div and triangle_unit_normal_top.
package tun_pkg;

    localparam int CB  = 20;
    localparam int NB  = 16;
    localparam int FB  = NB - 1;
    localparam int DB  = CB + 1;
    localparam int PB  = 2 * DB;
    localparam int MB  = PB + 1;
    localparam int LOB = (MB + 1) / 2;
    localparam int HIB = MB - LOB;
    localparam int SB  = 2 * MB + 2;
    localparam int RB  = SB / 2;
    localparam int RMB = RB + 2;
    localparam int LB  = 2 * CB;
    localparam int SH_R = (CB > FB) ? (CB - FB) : 0;
    localparam int SH_L = (FB > CB) ? (FB - CB) : 0;
    localparam int SIDE_N = RB + NB;

    localparam logic [FB-1:0] MAXV = {FB{1'b1}};
    localparam logic [CB-1:0] MIN_LENGTH_RST = CB'(1);

    typedef enum logic [1:0] {
        ST_NORM     = 2'd0,
        ST_UNNORM   = 2'd1,
        ST_FALLBACK = 2'd2
    } t_status;

    typedef struct packed {
        logic                  have;
        logic                  norm;
        logic [2:0]            neg;
        logic [2:0][MB-1:0]    mag;
        logic [2:0][FB-1:0]    un;
    } t_side;

    function automatic logic [FB-1:0] unnorm(input logic [MB-1:0] mag);
        logic [MB-1:0] m;
        m = mag >> SH_R;
        if (m > (MB'(MAXV) >> SH_L)) begin
            unnorm = MAXV;
        end else begin
            unnorm = FB'(m << SH_L);
        end
    endfunction

endpackage

// File: rtl/triangle_unit_normal_top.sv
// Triangle face normal: edge vectors, cross product, length and normalizing divide.
// Depends on tun_pkg, tun_isqrt and tun_div.
//
// One triangle transaction is taken every clock cycle unless the pipeline holds, and its result
// is presented after passing 68 register stages: 7 for the edge, cross product,
// squared length and threshold stages, 44 in the square root pipeline (one root bit per
// stage), 16 in the divider pipeline (one quotient bit per stage) and one output register.
// The whole pipeline holds while a result waits at the output; o_in_ready is low exactly then.
module triangle_unit_normal_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tun_pkg::CB-1:0]        i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_have_triangle,
    input  logic signed [tun_pkg::CB-1:0] i_ax,
    input  logic signed [tun_pkg::CB-1:0] i_ay,
    input  logic signed [tun_pkg::CB-1:0] i_az,
    input  logic signed [tun_pkg::CB-1:0] i_bx,
    input  logic signed [tun_pkg::CB-1:0] i_by_coord,
    input  logic signed [tun_pkg::CB-1:0] i_bz,
    input  logic signed [tun_pkg::CB-1:0] i_cx,
    input  logic signed [tun_pkg::CB-1:0] i_cy,
    input  logic signed [tun_pkg::CB-1:0] i_cz,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [tun_pkg::NB-1:0] o_nx,
    output logic signed [tun_pkg::NB-1:0] o_ny,
    output logic signed [tun_pkg::NB-1:0] o_nz,
    output logic [1:0]                    o_status
);

    localparam int CB  = tun_pkg::CB;
    localparam int NB  = tun_pkg::NB;
    localparam int FB  = tun_pkg::FB;
    localparam int DB  = tun_pkg::DB;
    localparam int PB  = tun_pkg::PB;
    localparam int MB  = tun_pkg::MB;
    localparam int LOB = tun_pkg::LOB;
    localparam int HIB = tun_pkg::HIB;
    localparam int SB  = tun_pkg::SB;
    localparam int RB  = tun_pkg::RB;
    localparam int LB  = tun_pkg::LB;
    localparam int SIDE_N = tun_pkg::SIDE_N;

    logic en;

    logic [CB-1:0] r_min_length;
    logic [LB-1:0] r_lim;

    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5, r_vld6, r_vld7;
    logic r_vld_side [0:SIDE_N-1];

    logic                  r1_have;
    logic signed [DB-1:0]  r1_u [0:2];
    logic signed [DB-1:0]  r1_v [0:2];

    logic                  r2_have;
    logic signed [PB-1:0]  r2_pa [0:2];
    logic signed [PB-1:0]  r2_pb [0:2];

    logic                  r3_have;
    logic [2:0]            r3_neg;
    logic [MB-1:0]         r3_mag [0:2];

    tun_pkg::t_side        r4_side, r5_side, r6_side, r7_side;
    tun_pkg::t_side        n_side7;
    logic [2*HIB-1:0]      r4_hh [0:2];
    logic [HIB+LOB-1:0]    r4_hl [0:2];
    logic [2*LOB-1:0]      r4_ll [0:2];
    logic [SB-1:0]         r5_sq [0:2];
    logic [SB-1:0]         r6_s;
    logic [SB-1:0]         r7_s;

    tun_pkg::t_side        r_side [0:SIDE_N-1];

    logic [RB-1:0]         w_root;
    logic [NB-1:0]         w_quo [0:2];

    logic                  r_out_valid;
    logic [NB-1:0]         r_out_n [0:2];
    tun_pkg::t_status      r_out_status;

    logic [NB-1:0]         n_out_n [0:2];
    tun_pkg::t_status      n_out_status;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= tun_pkg::MIN_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_min_length <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim <= LB'(r_min_length) * LB'(r_min_length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
            for (int k = 0; k < SIDE_N; k++) begin
                r_vld_side[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld1 <= i_in_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
            r_vld7 <= r_vld6;
            r_vld_side[0] <= r_vld7;
            for (int k = 1; k < SIDE_N; k++) begin
                r_vld_side[k] <= r_vld_side[k-1];
            end
            r_out_valid <= r_vld_side[SIDE_N-1];
        end
    end

    // edge vectors
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_have <= i_have_triangle;
            r1_u[0] <= DB'(i_bx) - DB'(i_ax);
            r1_u[1] <= DB'(i_by_coord) - DB'(i_ay);
            r1_u[2] <= DB'(i_bz) - DB'(i_az);
            r1_v[0] <= DB'(i_cx) - DB'(i_ax);
            r1_v[1] <= DB'(i_cy) - DB'(i_ay);
            r1_v[2] <= DB'(i_cz) - DB'(i_az);
        end
    end

    // cross product terms
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_have  <= r1_have;
            r2_pa[0] <= PB'(r1_u[1]) * PB'(r1_v[2]);
            r2_pb[0] <= PB'(r1_u[2]) * PB'(r1_v[1]);
            r2_pa[1] <= PB'(r1_u[2]) * PB'(r1_v[0]);
            r2_pb[1] <= PB'(r1_u[0]) * PB'(r1_v[2]);
            r2_pa[2] <= PB'(r1_u[0]) * PB'(r1_v[1]);
            r2_pb[2] <= PB'(r1_u[1]) * PB'(r1_v[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_have <= r2_have;
            for (int k = 0; k < 3; k++) begin
                logic signed [MB-1:0] p;
                p = MB'(r2_pa[k]) - MB'(r2_pb[k]);
                r3_neg[k] <= p[MB-1];
                r3_mag[k] <= p[MB-1] ? MB'(-p) : MB'(p);
            end
        end
    end

    // squared magnitudes as partial products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_side.have <= r3_have;
            r4_side.norm <= 1'b0;
            r4_side.neg  <= r3_neg;
            for (int k = 0; k < 3; k++) begin
                r4_side.mag[k] <= r3_mag[k];
                r4_side.un[k]  <= tun_pkg::unnorm(r3_mag[k]);
                r4_hh[k] <= (2*HIB)'(r3_mag[k][MB-1:LOB]) * (2*HIB)'(r3_mag[k][MB-1:LOB]);
                r4_hl[k] <= (HIB+LOB)'(r3_mag[k][MB-1:LOB]) * (HIB+LOB)'(r3_mag[k][LOB-1:0]);
                r4_ll[k] <= (2*LOB)'(r3_mag[k][LOB-1:0]) * (2*LOB)'(r3_mag[k][LOB-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_side <= r4_side;
            for (int k = 0; k < 3; k++) begin
                r5_sq[k] <= (SB'(r4_hh[k]) << (2*LOB)) + (SB'(r4_hl[k]) << (LOB+1))
                          + SB'(r4_ll[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_side <= r5_side;
            r6_s    <= r5_sq[0] + r5_sq[1] + r5_sq[2];
        end
    end

    always_comb begin
        n_side7      = r6_side;
        n_side7.norm = (r6_s > SB'(r_lim));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_side <= n_side7;
            r7_s    <= r6_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r7_side;
            for (int k = 1; k < SIDE_N; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    tun_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r7_s),
        .o_root (w_root)
    );

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            tun_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_mag (r_side[RB-1].mag[g]),
                .i_len (w_root),
                .o_quo (w_quo[g])
            );
        end
    endgenerate

    always_comb begin
        tun_pkg::t_side s;
        logic [FB-1:0]  m;
        s = r_side[SIDE_N-1];
        for (int k = 0; k < 3; k++) begin
            if (s.norm) begin
                m = (w_quo[k] > NB'(tun_pkg::MAXV)) ? tun_pkg::MAXV : w_quo[k][FB-1:0];
            end else begin
                m = s.un[k];
            end
            n_out_n[k] = s.neg[k] ? NB'(-{1'b0, m}) : {1'b0, m};
        end
        if (!s.have) begin
            n_out_n[0]   = '0;
            n_out_n[1]   = '0;
            n_out_n[2]   = {1'b0, tun_pkg::MAXV};
            n_out_status = tun_pkg::ST_FALLBACK;
        end else if (s.norm) begin
            n_out_status = tun_pkg::ST_NORM;
        end else begin
            n_out_status = tun_pkg::ST_UNNORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_n[0]   <= n_out_n[0];
            r_out_n[1]   <= n_out_n[1];
            r_out_n[2]   <= n_out_n[2];
            r_out_status <= n_out_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_nx        = r_out_n[0];
    assign o_ny        = r_out_n[1];
    assign o_nz        = r_out_n[2];
    assign o_status    = r_out_status;

endmodule

// File: rtl/tun_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on tun_pkg for widths.
module tun_isqrt (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tun_pkg::SB-1:0]    i_rad,
    output logic [tun_pkg::RB-1:0]    o_root
);

    localparam int SB  = tun_pkg::SB;
    localparam int RB  = tun_pkg::RB;
    localparam int RMB = tun_pkg::RMB;

    logic [RMB-1:0] r_rem  [1:RB-1];
    logic [SB-1:0]  r_rad  [1:RB-1];
    logic [RB-1:0]  r_root [1:RB];

    genvar g;
    generate
        for (g = 0; g < RB; g++) begin : g_stage
            logic [RMB-1:0] p_rem;
            logic [RB-1:0]  p_root;
            logic [SB-1:0]  p_rad;
            logic [RMB-1:0] n_cur;
            logic [RMB-1:0] n_trial;
            logic [RMB-1:0] n_rem;
            logic [RB-1:0]  n_root;

            if (g == 0) begin : g_first
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_rad  = i_rad;
            end else begin : g_next
                assign p_rem  = r_rem[g];
                assign p_root = r_root[g];
                assign p_rad  = r_rad[g];
            end

            always_comb begin
                n_cur   = {p_rem[RMB-3:0], p_rad[SB-1 -: 2]};
                n_trial = {p_root, 2'b01};
                if (n_cur >= n_trial) begin
                    n_rem  = n_cur - n_trial;
                    n_root = {p_root[RB-2:0], 1'b1};
                end else begin
                    n_rem  = n_cur;
                    n_root = {p_root[RB-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_root[g+1] <= n_root;
                end
            end

            if (g < RB - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[g+1] <= n_rem;
                        r_rad[g+1] <= {p_rad[SB-3:0], 2'b00};
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[RB];

endmodule

// File: rtl/tun_div.sv
// Pipelined restoring divider, one quotient bit per stage, for mag * 2^FB / len.
// Depends on tun_pkg; expects mag no larger than len.
module tun_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tun_pkg::MB-1:0]    i_mag,
    input  logic [tun_pkg::RB-1:0]    i_len,
    output logic [tun_pkg::NB-1:0]    o_quo
);

    localparam int NB = tun_pkg::NB;
    localparam int RB = tun_pkg::RB;
    localparam int RW = RB + 1;

    logic [RW-1:0] r_rem [1:NB-1];
    logic [RB-1:0] r_len [1:NB-1];
    logic [NB-1:0] r_quo [1:NB];

    genvar g;
    generate
        for (g = 0; g < NB; g++) begin : g_stage
            logic [RW-1:0] n_cur;
            logic [RB-1:0] p_len;
            logic [NB-1:0] p_quo;
            logic          n_bit;
            logic [RW-1:0] n_rem;

            if (g == 0) begin : g_first
                assign n_cur = RW'(i_mag);
                assign p_len = i_len;
                assign p_quo = '0;
            end else begin : g_next
                assign n_cur = {r_rem[g][RW-2:0], 1'b0};
                assign p_len = r_len[g];
                assign p_quo = r_quo[g];
            end

            always_comb begin
                n_bit = (n_cur >= {1'b0, p_len});
                n_rem = n_bit ? (n_cur - {1'b0, p_len}) : n_cur;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[g+1] <= {p_quo[NB-2:0], n_bit};
                end
            end

            if (g < NB - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[g+1] <= n_rem;
                        r_len[g+1] <= p_len;
                    end
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[NB];

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for triangle_unit_normal_top: random and directed triangles,
// expected normals computed by an internal wide-integer model. Depends on tun_pkg.
module tb;

    localparam int CB = tun_pkg::CB;
    localparam int NB = tun_pkg::NB;
    localparam int FB = tun_pkg::FB;

    localparam int N_RANDOM = 1800;
    localparam int WDOG_LIMIT = 4000;
    localparam int N_DIRECTED = 16;

    typedef struct {
        logic                 have;
        logic signed [CB-1:0] c [9];
    } t_tri;

    typedef struct {
        logic signed [NB-1:0] nx;
        logic signed [NB-1:0] ny;
        logic signed [NB-1:0] nz;
        tun_pkg::t_status     status;
    } t_normal;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CB-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_have_triangle = 1'b0;
    logic signed [CB-1:0] i_ax = '0, i_ay = '0, i_az = '0;
    logic signed [CB-1:0] i_bx = '0, i_by_coord = '0, i_bz = '0;
    logic signed [CB-1:0] i_cx = '0, i_cy = '0, i_cz = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [NB-1:0] o_nx, o_ny, o_nz;
    logic [1:0] o_status;

    logic [CB-1:0] min_len;
    t_normal normal_q[$];
    int errors = 0;
    int idle_cycles = 0;

    triangle_unit_normal_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_have_triangle(i_have_triangle),
        .i_ax(i_ax), .i_ay(i_ay), .i_az(i_az),
        .i_bx(i_bx), .i_by_coord(i_by_coord), .i_bz(i_bz),
        .i_cx(i_cx), .i_cy(i_cy), .i_cz(i_cz),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_nx(o_nx), .o_ny(o_ny), .o_nz(o_nz), .o_status(o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [63:0] root_floor(input logic [127:0] s);
        logic [63:0] r, c;
        r = '0;
        for (int b = 62; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= s) r = c;
        end
        return r;
    endfunction

    function automatic logic [NB-1:0] with_sign(input logic neg, input logic [FB-1:0] m);
        logic [NB-1:0] v;
        v = {1'b0, m};
        return neg ? -v : v;
    endfunction

    function automatic t_normal face_normal(input t_tri t);
        t_normal r;
        logic signed [63:0] u [3], v [3], p [3];
        logic [63:0] mag [3];
        logic [127:0] sq, q, m;
        logic [63:0] len;
        logic [FB-1:0] comp [3];
        if (!t.have) begin
            r.nx = '0; r.ny = '0; r.nz = with_sign(1'b0, tun_pkg::MAXV);
            r.status = tun_pkg::ST_FALLBACK;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            u[i] = 64'(t.c[3 + i]) - 64'(t.c[i]);
            v[i] = 64'(t.c[6 + i]) - 64'(t.c[i]);
        end
        p[0] = u[1] * v[2] - u[2] * v[1];
        p[1] = u[2] * v[0] - u[0] * v[2];
        p[2] = u[0] * v[1] - u[1] * v[0];
        sq = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = p[i] < 0 ? -p[i] : p[i];
            sq += 128'(mag[i]) * 128'(mag[i]);
        end
        if (sq > 128'(min_len) * 128'(min_len)) begin
            len = root_floor(sq);
            for (int i = 0; i < 3; i++) begin
                q = (128'(mag[i]) << FB) / 128'(len);
                comp[i] = q > 128'(tun_pkg::MAXV) ? tun_pkg::MAXV : FB'(q);
            end
            r.status = tun_pkg::ST_NORM;
        end else begin
            for (int i = 0; i < 3; i++) begin
                m = 128'(mag[i]) >> (CB - FB);
                comp[i] = m > 128'(tun_pkg::MAXV) ? tun_pkg::MAXV : FB'(m);
            end
            r.status = tun_pkg::ST_UNNORM;
        end
        r.nx = with_sign(p[0] < 0, comp[0]);
        r.ny = with_sign(p[1] < 0, comp[1]);
        r.nz = with_sign(p[2] < 0, comp[2]);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_min_length(input logic [CB-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        min_len = val;
    endtask

    task automatic send_triangle(input t_tri t);
        int idle;
        idle = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 12) : 0;
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_have_triangle <= t.have;
        i_ax <= t.c[0]; i_ay <= t.c[1]; i_az <= t.c[2];
        i_bx <= t.c[3]; i_by_coord <= t.c[4]; i_bz <= t.c[5];
        i_cx <= t.c[6]; i_cy <= t.c[7]; i_cz <= t.c[8];
        do @(posedge i_clk); while (!o_in_ready);
        normal_q = {normal_q, face_normal(t)};
    endtask

    function automatic logic signed [CB-1:0] rand_coord(input int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($signed($urandom_range(0, 4095)) - 2048);
            2: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
            default: return CB'($signed($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    function automatic t_tri rand_triangle();
        t_tri t;
        int mode;
        mode = $urandom_range(0, 3);
        t.have = $urandom_range(0, 9) != 0;
        for (int i = 0; i < 9; i++) t.c[i] = rand_coord($urandom_range(0, 4) == 0 ? 0 : mode);
        if ($urandom_range(0, 15) == 0) begin
            for (int i = 3; i < 6; i++) t.c[i + 3] = t.c[i];
        end
        return t;
    endfunction

    always @(posedge i_clk) begin
        t_normal e;
        if (o_out_valid && i_out_ready) begin
            if (normal_q.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                e = normal_q.pop_front();
                if (o_nx !== e.nx) report_mismatch("nx", o_nx, e.nx);
                if (o_ny !== e.ny) report_mismatch("ny", o_ny, e.ny);
                if (o_nz !== e.nz) report_mismatch("nz", o_nz, e.nz);
                if (o_status !== e.status) report_mismatch("status", o_status, e.status);
            end
        end
    end

    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall = 0;
        end else if (stall > 0) begin
            stall--;
            i_out_ready <= 1'b0;
        end else if (!i_out_ready || o_out_valid) begin
            stall = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
            i_out_ready <= stall == 0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    logic [CB-1:0] cfg_sweep [4] = '{20'hFFFFF, 20'd0, 20'd4096, 20'd1 << 12};

    initial begin
        t_tri t;
        t_tri dir_tri [N_DIRECTED];
        t_normal dir_want [N_DIRECTED];
        bit dir_fixed [N_DIRECTED];
        min_len = tun_pkg::MIN_LENGTH_RST;
        for (int k = 0; k < N_DIRECTED; k++) begin
            dir_tri[k].have = 1'b1;
            for (int i = 0; i < 9; i++) dir_tri[k].c[i] = '0;
            dir_fixed[k] = 0;
        end
        dir_tri[0].have = 1'b0;
        for (int i = 0; i < 9; i++) dir_tri[0].c[i] = '1;
        dir_want[0] = '{0, 0, 16'sd32767, tun_pkg::ST_FALLBACK}; dir_fixed[0] = 1;
        dir_want[1] = '{0, 0, 0, tun_pkg::ST_UNNORM}; dir_fixed[1] = 1;
        dir_tri[2].c[3] = 20'sd1024; dir_tri[2].c[7] = 20'sd1024;
        dir_want[2] = '{0, 0, 16'sd32767, tun_pkg::ST_NORM}; dir_fixed[2] = 1;
        dir_tri[3].c[4] = 20'sd1024; dir_tri[3].c[8] = 20'sd1024;
        dir_want[3] = '{16'sd32767, 0, 0, tun_pkg::ST_NORM}; dir_fixed[3] = 1;
        dir_tri[4].c[4] = 20'sd1024; dir_tri[4].c[6] = 20'sd1024;
        dir_want[4] = '{0, 0, -16'sd32767, tun_pkg::ST_NORM}; dir_fixed[4] = 1;
        dir_tri[5].c[3] = 20'sd1; dir_tri[5].c[7] = 20'sd1;
        for (int k = 6; k < 10; k++) begin
            for (int i = 0; i < 9; i++) dir_tri[k].c[i] = rand_coord(2);
        end
        for (int i = 0; i < 3; i++) begin
            dir_tri[10].c[i] = {1'b1, {(CB-1){1'b0}}};
            dir_tri[11].c[i] = {1'b0, {(CB-1){1'b1}}};
        end
        dir_tri[10].c[3] = {1'b0, {(CB-1){1'b1}}}; dir_tri[10].c[7] = {1'b0, {(CB-1){1'b1}}};
        dir_tri[11].c[4] = {1'b1, {(CB-1){1'b0}}}; dir_tri[11].c[8] = {1'b1, {(CB-1){1'b0}}};
        for (int k = 12; k < N_DIRECTED; k++) dir_tri[k] = rand_triangle();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            send_triangle(dir_tri[k]);
            if (dir_fixed[k]) normal_q[normal_q.size() - 1] = dir_want[k];
        end
        wait_drained();

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) write_min_length(cfg_sweep[ph - 1]);
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                if (n == 150) wait_drained();
                t = rand_triangle();
                if (ph == 0 && n < 10) begin
                    t.have = 1'b1;
                    t.c[3] = t.c[0]; t.c[4] = t.c[1]; t.c[5] = t.c[2];
                    t.c[6] = t.c[0]; t.c[7] = t.c[1]; t.c[8] = t.c[2] + CB'(n);
                end
                send_triangle(t);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
